FILE: rtl/jpc_pkg.sv
`timescale 1ns / 1ps

package jpc_pkg;

	// Defaults for the top level parameters
	localparam int CAL_SAMPLES_DEF = 24;
	localparam int CURSOR_MAX_DEF  = 127;

	// Fixed field widths
	localparam int SAMPLE_W   = 12;
	localparam int TOUCH_W    = 16;
	localparam int CURSOR_W   = 7;
	localparam int DIVISOR_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Register reset values
	localparam logic [5:0]  DEADZONE_RST  = 6'd16;
	localparam logic [3:0]  SPEED_RST     = 4'd4;
	localparam logic [6:0]  TOUCH_THR_RST = 7'd24;
	localparam logic        TOUCH_EN_RST  = 1'b1;
	localparam logic [SAMPLE_W-1:0] MID_RST = 12'd2048;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADZONE  = 2'd0,
		REG_SPEED     = 2'd1,
		REG_TOUCH_THR = 2'd2,
		REG_TOUCH_EN  = 2'd3
	} jpc_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_COMMIT
	} jpc_state_t;

	typedef struct packed {
		logic capture;
		logic start;
		logic commit;
	} jpc_cmd_t;

	typedef struct packed {
		logic div_busy;
	} jpc_stat_t;

	// Step divisor: max(1, 128 / max(1, speed))
	function automatic logic [DIVISOR_W-1:0] speed_divisor(input logic [3:0] spd);
		logic [DIVISOR_W-1:0] d;
		case (spd)
			4'd0:    d = 8'd128;
			4'd1:    d = 8'd128;
			4'd2:    d = 8'd64;
			4'd3:    d = 8'd42;
			4'd4:    d = 8'd32;
			4'd5:    d = 8'd25;
			4'd6:    d = 8'd21;
			4'd7:    d = 8'd18;
			4'd8:    d = 8'd16;
			4'd9:    d = 8'd14;
			4'd10:   d = 8'd12;
			4'd11:   d = 8'd11;
			4'd12:   d = 8'd10;
			4'd13:   d = 8'd9;
			4'd14:   d = 8'd9;
			default: d = 8'd8;
		endcase
		return d;
	endfunction

endpackage

FILE: rtl/jpc_div.sv
`timescale 1ns / 1ps

module jpc_div #(
	parameter int W  = 17,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [W-1:0]  quotient
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DW:0]      shifted;
	logic [DW:0]      diff;
	logic             fits;

	// Restoring division, one quotient bit a cycle
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/jpc_ctrl.sv
`timescale 1ns / 1ps

module jpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  jpc_pkg::jpc_stat_t stat,
	output jpc_pkg::jpc_cmd_t  cmd_o
);

	import jpc_pkg::*;

	jpc_state_t state_q;
	jpc_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_o.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd_o.capture = 1'b0;
		cmd_o.start   = 1'b0;
		cmd_o.commit  = 1'b0;
		in_stall      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd_o.capture = 1'b1;
					state_d       = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd_o.start = 1'b1;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd_o.commit = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/jpc_datapath.sv
`timescale 1ns / 1ps

module jpc_datapath #(
	parameter int CAL_SAMPLES = jpc_pkg::CAL_SAMPLES_DEF,
	parameter int CURSOR_MAX  = jpc_pkg::CURSOR_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  jpc_pkg::jpc_cmd_t               cmd_i,
	output jpc_pkg::jpc_stat_t              stat,
	input  logic                            cfg_we,
	input  logic [jpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            cmd,
	input  logic [jpc_pkg::SAMPLE_W-1:0]    joy_x,
	input  logic [jpc_pkg::SAMPLE_W-1:0]    joy_y,
	input  logic                            click_pressed,
	input  logic [jpc_pkg::TOUCH_W-1:0]     touch_value,
	output logic [jpc_pkg::CURSOR_W-1:0]    cursor_x,
	output logic [jpc_pkg::CURSOR_W-1:0]    cursor_y,
	output logic                            left_held,
	output logic                            left_pressed,
	output logic                            left_released,
	output logic                            right_held,
	output logic                            right_pressed,
	output logic                            right_released,
	output logic                            changed,
	output logic [jpc_pkg::SAMPLE_W-1:0]    center_x,
	output logic [jpc_pkg::SAMPLE_W-1:0]    center_y,
	output logic                            calib_done
);

	import jpc_pkg::*;

	localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
	localparam int ACC_W  = SAMPLE_W + CNT_W;
	localparam int POS_W  = $clog2(CURSOR_MAX + 1);
	localparam int SW     = ((SAMPLE_W > POS_W) ? SAMPLE_W : POS_W) + 2;
	// Average by reciprocal: floor(sum * M / 2^S) equals sum / CAL_SAMPLES
	localparam int RCP_S  = ACC_W + $clog2(CAL_SAMPLES);
	localparam int PROD_W = 2 * ACC_W + 1;
	localparam logic [ACC_W:0] RCP_M =
		(ACC_W + 1)'(((1 << RCP_S) + CAL_SAMPLES - 1) / CAL_SAMPLES);

	// Configuration registers
	logic [5:0] deadzone_q;
	logic [3:0] speed_q;
	logic [6:0] touch_thr_q;
	logic       touch_en_q;

	// Captured item
	logic                cmd_q;
	logic [SAMPLE_W-1:0] jx_q;
	logic [SAMPLE_W-1:0] jy_q;
	logic                click_q;
	logic [TOUCH_W-1:0]  touch_q;

	// Block state
	logic [POS_W-1:0]    pos_x_q;
	logic [POS_W-1:0]    pos_y_q;
	logic                left_q;
	logic                right_q;
	logic [SAMPLE_W-1:0] mid_x_q;
	logic [SAMPLE_W-1:0] mid_y_q;
	logic [ACC_W-1:0]    acc_x_q;
	logic [ACC_W-1:0]    acc_y_q;
	logic [CNT_W-1:0]    cnt_q;

	// Output register
	logic [CURSOR_W-1:0] cursor_x_q;
	logic [CURSOR_W-1:0] cursor_y_q;
	logic                left_held_q;
	logic                left_pressed_q;
	logic                left_released_q;
	logic                right_held_q;
	logic                right_pressed_q;
	logic                right_released_q;
	logic                changed_q;
	logic [SAMPLE_W-1:0] center_x_q;
	logic [SAMPLE_W-1:0] center_y_q;
	logic                calib_done_q;

	logic [SAMPLE_W:0]    off_x;
	logic [SAMPLE_W:0]    off_y;
	logic [SAMPLE_W:0]    neg_off_x;
	logic [SAMPLE_W:0]    neg_off_y;
	logic                 neg_x;
	logic                 neg_y;
	logic [SAMPLE_W-1:0]  mag_x;
	logic [SAMPLE_W-1:0]  mag_y;
	logic [SAMPLE_W-1:0]  thr;
	logic [ACC_W-1:0]     sum_x;
	logic [ACC_W-1:0]     sum_y;
	logic [PROD_W-1:0]    prod_x;
	logic [PROD_W-1:0]    prod_y;
	logic [SAMPLE_W-1:0]  avg_x;
	logic [SAMPLE_W-1:0]  avg_y;
	logic [SAMPLE_W-1:0]  dvd_x;
	logic [SAMPLE_W-1:0]  dvd_y;
	logic [DIVISOR_W-1:0] dvs;
	logic [SAMPLE_W-1:0]  q_x;
	logic [SAMPLE_W-1:0]  q_y;
	logic                 busy_x;
	logic                 busy_y;
	logic                 last;
	logic                 right_now;
	logic [POS_W-1:0]     new_pos_x;
	logic [POS_W-1:0]     new_pos_y;
	logic [POS_W+CURSOR_W-1:0] ext_x;
	logic [POS_W+CURSOR_W-1:0] ext_y;

	function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] pos,
		input logic [SAMPLE_W-1:0] q, input logic neg);
		logic [SW-1:0] sum;
		logic [POS_W-1:0] r;
		sum = neg ? (SW'(pos) - SW'(q)) : (SW'(pos) + SW'(q));
		if (sum[SW-1]) begin
			r = '0;
		end else if (sum > SW'(CURSOR_MAX)) begin
			r = POS_W'(CURSOR_MAX);
		end else begin
			r = sum[POS_W-1:0];
		end
		return r;
	endfunction

	// Offsets, dead zone, divide operands, calibration averages, touch level and clamped positions
	always_comb begin
		off_x     = {1'b0, jx_q} - {1'b0, mid_x_q};
		off_y     = {1'b0, jy_q} - {1'b0, mid_y_q};
		neg_off_x = -off_x;
		neg_off_y = -off_y;
		neg_x     = off_x[SAMPLE_W];
		neg_y     = off_y[SAMPLE_W];
		mag_x     = neg_x ? neg_off_x[SAMPLE_W-1:0] : off_x[SAMPLE_W-1:0];
		mag_y     = neg_y ? neg_off_y[SAMPLE_W-1:0] : off_y[SAMPLE_W-1:0];
		thr       = {2'b00, deadzone_q, 4'b0000};
		sum_x     = acc_x_q + ACC_W'(jx_q);
		sum_y     = acc_y_q + ACC_W'(jy_q);
		prod_x    = {{(ACC_W + 1){1'b0}}, sum_x} * {{ACC_W{1'b0}}, RCP_M};
		prod_y    = {{(ACC_W + 1){1'b0}}, sum_y} * {{ACC_W{1'b0}}, RCP_M};
		avg_x     = prod_x[RCP_S +: SAMPLE_W];
		avg_y     = prod_y[RCP_S +: SAMPLE_W];
		dvd_x     = (!cmd_q && (mag_x > thr)) ? mag_x : '0;
		dvd_y     = (!cmd_q && (mag_y > thr)) ? mag_y : '0;
		dvs       = speed_divisor(speed_q);
		last      = ({1'b0, cnt_q} + 1'b1) >= (CNT_W + 1)'(CAL_SAMPLES);
		right_now = touch_en_q && (touch_q < TOUCH_W'(touch_thr_q));
		new_pos_x = step_pos(pos_x_q, q_x, neg_x);
		new_pos_y = step_pos(pos_y_q, q_y, neg_y);
		ext_x     = {{CURSOR_W{1'b0}}, (cmd_q ? pos_x_q : new_pos_x)};
		ext_y     = {{CURSOR_W{1'b0}}, (cmd_q ? pos_y_q : new_pos_y)};
	end

	jpc_div #(.W(SAMPLE_W), .DW(DIVISOR_W)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd_i.start),
		.dividend (dvd_x),
		.divisor  (dvs),
		.busy     (busy_x),
		.quotient (q_x)
	);

	jpc_div #(.W(SAMPLE_W), .DW(DIVISOR_W)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd_i.start),
		.dividend (dvd_y),
		.divisor  (dvs),
		.busy     (busy_y),
		.quotient (q_y)
	);

	assign stat.div_busy = busy_x || busy_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q  <= DEADZONE_RST;
			speed_q     <= SPEED_RST;
			touch_thr_q <= TOUCH_THR_RST;
			touch_en_q  <= TOUCH_EN_RST;
		end else if (cfg_we) begin
			case (jpc_reg_t'(cfg_index))
				REG_DEADZONE:  deadzone_q  <= cfg_wdata[5:0];
				REG_SPEED:     speed_q     <= cfg_wdata[3:0];
				REG_TOUCH_THR: touch_thr_q <= cfg_wdata[6:0];
				REG_TOUCH_EN:  touch_en_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.capture) begin
			cmd_q   <= cmd;
			jx_q    <= joy_x;
			jy_q    <= joy_y;
			click_q <= click_pressed;
			touch_q <= touch_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			left_q  <= 1'b0;
			right_q <= 1'b0;
			mid_x_q <= MID_RST;
			mid_y_q <= MID_RST;
			acc_x_q <= '0;
			acc_y_q <= '0;
			cnt_q   <= '0;
		end else if (cmd_i.commit) begin
			if (cmd_q) begin
				if (last) begin
					mid_x_q <= avg_x;
					mid_y_q <= avg_y;
					acc_x_q <= '0;
					acc_y_q <= '0;
					cnt_q   <= '0;
				end else begin
					acc_x_q <= sum_x;
					acc_y_q <= sum_y;
					cnt_q   <= cnt_q + 1'b1;
				end
			end else begin
				pos_x_q <= new_pos_x;
				pos_y_q <= new_pos_y;
				left_q  <= click_q;
				right_q <= right_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.commit) begin
			cursor_x_q       <= ext_x[CURSOR_W-1:0];
			cursor_y_q       <= ext_y[CURSOR_W-1:0];
			left_held_q      <= cmd_q ? left_q : click_q;
			left_pressed_q   <= !cmd_q && click_q && !left_q;
			left_released_q  <= !cmd_q && !click_q && left_q;
			right_held_q     <= cmd_q ? right_q : right_now;
			right_pressed_q  <= !cmd_q && right_now && !right_q;
			right_released_q <= !cmd_q && !right_now && right_q;
			changed_q        <= cmd_q ? last :
				((q_x != '0) || (q_y != '0) || (click_q != left_q) || (right_now != right_q));
			center_x_q       <= (cmd_q && last) ? avg_x : mid_x_q;
			center_y_q       <= (cmd_q && last) ? avg_y : mid_y_q;
			calib_done_q     <= cmd_q && last;
		end
	end

	assign cursor_x       = cursor_x_q;
	assign cursor_y       = cursor_y_q;
	assign left_held      = left_held_q;
	assign left_pressed   = left_pressed_q;
	assign left_released  = left_released_q;
	assign right_held     = right_held_q;
	assign right_pressed  = right_pressed_q;
	assign right_released = right_released_q;
	assign changed        = changed_q;
	assign center_x       = center_x_q;
	assign center_y       = center_y_q;
	assign calib_done     = calib_done_q;

endmodule

FILE: rtl/joystick_pointer_controller_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_stall   cmd, joy_x, joy_y, click_pressed, touch_value
// output    out_valid / out_stall cursor_x .. calib_done (one result per item)
// config    cfg_we                cfg_index, cfg_wdata (write only)
//
// An item is captured on transfer and both axis divides start; the sequencer
// waits for the bit-serial divider pair (W = 12, the sample width), then commits
// state and loads the result, and no new transfer is taken before that commit.
// The calibration average is a constant reciprocal multiply and is combinational.
// Reset sets the state machine, the configuration registers, cursor, button
// levels, centres (2048) and the calibration accumulators to their reset values.
// The next item is taken while a result waits; a stalled result holds the
// finished item in the commit step until the output register frees up.

module joystick_pointer_controller_unit #(
	parameter int CAL_SAMPLES = jpc_pkg::CAL_SAMPLES_DEF,
	parameter int CURSOR_MAX  = jpc_pkg::CURSOR_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [jpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [jpc_pkg::SAMPLE_W-1:0]    joy_x,
	input  logic [jpc_pkg::SAMPLE_W-1:0]    joy_y,
	input  logic                            click_pressed,
	input  logic [jpc_pkg::TOUCH_W-1:0]     touch_value,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [jpc_pkg::CURSOR_W-1:0]    cursor_x,
	output logic [jpc_pkg::CURSOR_W-1:0]    cursor_y,
	output logic                            left_held,
	output logic                            left_pressed,
	output logic                            left_released,
	output logic                            right_held,
	output logic                            right_pressed,
	output logic                            right_released,
	output logic                            changed,
	output logic [jpc_pkg::SAMPLE_W-1:0]    center_x,
	output logic [jpc_pkg::SAMPLE_W-1:0]    center_y,
	output logic                            calib_done
);

	import jpc_pkg::*;

	// Commands from the sequencer, status back from the datapath
	jpc_cmd_t  dp_cmd;
	jpc_stat_t dp_stat;

	// Sequencer: capture the transfer, start both axis divides, wait, then
	// commit state and load the output register once it is free
	jpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd_o     (dp_cmd)
	);

	// Datapath: configuration, captured item, centre offsets and dead zone,
	// two dividers for the step size, reciprocal multiply for the calibration
	// average, clamp, buttons
	jpc_datapath #(
		.CAL_SAMPLES (CAL_SAMPLES),
		.CURSOR_MAX  (CURSOR_MAX)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_i          (dp_cmd),
		.stat           (dp_stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.joy_x          (joy_x),
		.joy_y          (joy_y),
		.click_pressed  (click_pressed),
		.touch_value    (touch_value),
		.cursor_x       (cursor_x),
		.cursor_y       (cursor_y),
		.left_held      (left_held),
		.left_pressed   (left_pressed),
		.left_released  (left_released),
		.right_held     (right_held),
		.right_pressed  (right_pressed),
		.right_released (right_released),
		.changed        (changed),
		.center_x       (center_x),
		.center_y       (center_y),
		.calib_done     (calib_done)
	);

endmodule
